// ----- sv/ddwo_pkg.sv -----
// Shared types, register indexes and codes for the wheel odometry block.
// No dependencies.
`default_nettype none
package ddwo_pkg;
   localparam int CsrIdxW = 2;
   localparam int CsrDataW = 32;
   localparam logic [CsrIdxW-1:0] RegTickAngle = 2'd0;
   localparam logic [CsrIdxW-1:0] RegWheelRadius = 2'd1;
   localparam logic [CsrIdxW-1:0] RegWheelBase = 2'd2;
   localparam logic OpSample = 1'b0;
   localparam logic OpClear = 1'b1;
   // quotient width of the shared divider lanes
   localparam int QuoW = 64;
   localparam int NumLanes = 2;

   typedef struct packed {
      logic operation;
      logic [15:0] stamp_ms;
      logic [15:0] left_count;
      logic [15:0] right_count;
   } req_type;

   typedef struct packed {
      logic signed [31:0] distance_step;
      logic signed [31:0] heading_step;
      logic signed [31:0] forward_rate;
      logic signed [31:0] turn_rate;
      logic signed [47:0] left_angle;
      logic signed [47:0] right_angle;
      logic signed [31:0] left_rate;
      logic signed [31:0] right_rate;
   } rsp_type;

   // one lane job: unsigned magnitude / divisor, with sign of result
   typedef struct packed {
      logic start;
      logic neg;
      logic [QuoW-1:0] num;
      logic [QuoW-1:0] den;
   } div_req_type;

   typedef enum logic [2:0] {
      StIdle, StMul, StHead, StWheel, StBody, StOut
   } state_type;

   function automatic logic [31:0] sat32(input logic neg, input logic [QuoW-1:0] m);
      logic [31:0] r;
      if (!neg) r = (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
      else if (m >= 64'h8000_0000) r = 32'h8000_0000;
      else r = 32'd0 - m[31:0];
      return r;
   endfunction
endpackage
`default_nettype wire

// ----- sv/ddwo_if.sv -----
// Valid/ready channel interface carrying one payload type.
// Depends on ddwo_pkg.
`default_nettype none
interface ddwo_req_if;
   logic valid;
   logic ready;
   ddwo_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ddwo_rsp_if;
   logic valid;
   logic ready;
   ddwo_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/ddwo_div_lane.sv -----
// Radix-2 restoring divider lane, one quotient bit per cycle, signed result
// saturated to 32 bits. Depends on ddwo_pkg.
`default_nettype none
module ddwo_div_lane (
   input wire logic clock,
   input wire logic reset,
   input wire ddwo_pkg::div_req_type job,
   output logic busy,
   output logic [31:0] result
);
   logic [ddwo_pkg::QuoW-1:0] quo_ff, quo_in, rem_ff, rem_in, den_ff, den_in;
   logic neg_ff, neg_in, busy_ff, busy_in;
   logic [6:0] cnt_ff, cnt_in;
   logic [ddwo_pkg::QuoW:0] trial;

   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; den_in = den_ff;
      neg_in = neg_ff; busy_in = busy_ff; cnt_in = cnt_ff;
      trial = {rem_ff, quo_ff[ddwo_pkg::QuoW-1]} - {1'b0, den_ff};
      if (job.start) begin
         quo_in = job.num; rem_in = '0; den_in = job.den;
         neg_in = job.neg; busy_in = 1'b1;
         cnt_in = 7'(ddwo_pkg::QuoW);
      end else if (busy_ff) begin
         // shift in one numerator bit, subtract when it fits
         if (!trial[ddwo_pkg::QuoW]) begin
            rem_in = trial[ddwo_pkg::QuoW-1:0];
            quo_in = {quo_ff[ddwo_pkg::QuoW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[ddwo_pkg::QuoW-2:0], quo_ff[ddwo_pkg::QuoW-1]};
            quo_in = {quo_ff[ddwo_pkg::QuoW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in; rem_ff <= rem_in; den_ff <= den_in; neg_ff <= neg_in;
   end

   assign busy = busy_ff;
   assign result = ddwo_pkg::sat32(neg_ff, quo_ff);
endmodule
`default_nettype wire

// ----- sv/diff_drive_wheel_odometry.sv -----
// Differential-drive wheel odometry top level: sequencer, state, two divider
// lanes. Depends on ddwo_pkg, ddwo_if, ddwo_div_lane.
`default_nettype none
// One transaction at a time. The next request is taken as soon as the current
// result is loaded into the output register. A clear goes straight to StOut,
// which loads its result into the output register. A sample runs three
// division steps on two bit-serial divider lanes: the heading on one lane, then
// both wheel rates side by side, then both body rates side by side. Each step
// has a start cycle, 64 quotient bits and a hand-off cycle. An unchanged stamp
// skips the wheel-rate step. An unchanged stamp with a zero stored delta also
// skips the body-rate step. A result still waiting in the output register holds
// the next one in StOut, which blocks the input until the register frees. Write
// registers through csr_* only while the block is idle.
module diff_drive_wheel_odometry (
   input wire logic clock,
   input wire logic reset,
   ddwo_req_if.sink req_ch,
   ddwo_rsp_if.source rsp_ch,
   input wire logic csr_write,
   input wire logic [ddwo_pkg::CsrIdxW-1:0] csr_index,
   input wire logic [ddwo_pkg::CsrDataW-1:0] csr_data
);
   localparam int W = ddwo_pkg::QuoW;
   logic [31:0] tick_ff;
   logic [15:0] radius_ff;
   logic [19:0] base_ff;
   logic [15:0] prev_l_ff, prev_r_ff, prev_st_ff, dms_ff;
   logic primed_ff;
   logic [47:0] ltot_ff, rtot_ff;
   logic [31:0] lspd_ff, rspd_ff;
   ddwo_pkg::state_type st_ff, st_in;
   ddwo_pkg::req_type cur_ff;
   logic signed [47:0] sl_ff, sr_ff;
   logic [31:0] dist_ff, head_ff;
   logic [31:0] fwd_ff, turn_ff;
   ddwo_pkg::rsp_type out_ff;
   logic out_v_ff;
   logic wait_ff;
   ddwo_pkg::div_req_type job [ddwo_pkg::NumLanes];
   logic [ddwo_pkg::NumLanes-1:0] busy;
   logic [31:0] res [ddwo_pkg::NumLanes];

   for (genvar g = 0; g < ddwo_pkg::NumLanes; g++) begin : g_lane
      ddwo_div_lane u_lane (.clock, .reset, .job(job[g]), .busy(busy[g]),
                            .result(res[g]));
   end

   // combinational helpers
   logic [15:0] lc, rc, dl, dr, dt_raw, dt_abs, dms_abs;
   logic signed [48:0] sum, diff;
   logic [48:0] msum, mdiff;
   logic [64:0] dist_prod;
   logic [W-1:0] dt_mag;
   logic dt_neg, stamp_new;
   logic [47:0] msl, msr;
   logic [31:0] dist_abs, head_abs;

   always_comb begin
      lc = primed_ff ? prev_l_ff : cur_ff.left_count;
      rc = primed_ff ? prev_r_ff : cur_ff.right_count;
      dl = cur_ff.left_count - lc;
      dr = cur_ff.right_count - rc;
      sum = 49'(sl_ff) + 49'(sr_ff);
      diff = 49'(sr_ff) - 49'(sl_ff);
      msum = sum[48] ? 49'd0 - sum : sum;
      mdiff = diff[48] ? 49'd0 - diff : diff;
      dist_prod = 65'(msum) * 65'(radius_ff);
      stamp_new = cur_ff.stamp_ms != prev_st_ff;
      dt_raw = stamp_new ? cur_ff.stamp_ms - prev_st_ff : dms_ff;
      dt_neg = dt_raw[15];
      dt_abs = dt_neg ? 16'd0 - dt_raw : dt_raw;
      dt_mag = W'(dt_abs);
      msl = sl_ff[47] ? 48'd0 - sl_ff : sl_ff;
      msr = sr_ff[47] ? 48'd0 - sr_ff : sr_ff;
      dist_abs = dist_ff[31] ? 32'd0 - dist_ff : dist_ff;
      head_abs = head_ff[31] ? 32'd0 - head_ff : head_ff;
      dms_abs = dms_ff[15] ? 16'd0 - dms_ff : dms_ff;
   end

   always_comb begin
      st_in = st_ff;
      for (int i = 0; i < ddwo_pkg::NumLanes; i++) job[i] = '0;
      unique case (st_ff)
         ddwo_pkg::StIdle: if (req_ch.valid) begin
            st_in = (req_ch.data.operation == ddwo_pkg::OpClear) ? ddwo_pkg::StOut
                                                                    : ddwo_pkg::StMul;
         end
         ddwo_pkg::StMul: st_in = ddwo_pkg::StHead;
         ddwo_pkg::StHead: begin
            if (!wait_ff) begin
               job[0].start = 1'b1; job[0].neg = diff[48];
               job[0].num = W'(mdiff) * W'(radius_ff);
               job[0].den = W'({(base_ff == 20'd0) ? 20'd1 : base_ff, 8'd0});
            end else if (!busy[0]) st_in = ddwo_pkg::StWheel;
         end
         ddwo_pkg::StWheel: begin
            if (!stamp_new || dt_raw == 16'd0) st_in = ddwo_pkg::StBody;
            else if (!wait_ff) begin
               job[0].start = 1'b1; job[0].neg = sl_ff[47] != dt_neg;
               job[0].num = W'(msl) * W'(1000); job[0].den = dt_mag << 16;
               job[1].start = 1'b1; job[1].neg = sr_ff[47] != dt_neg;
               job[1].num = W'(msr) * W'(1000); job[1].den = dt_mag << 16;
            end else if (busy == '0) st_in = ddwo_pkg::StBody;
         end
         ddwo_pkg::StBody: begin
            if (dms_ff == 16'd0 && !stamp_new) st_in = ddwo_pkg::StOut;
            else if (!wait_ff) begin
               job[0].start = 1'b1; job[0].neg = dist_ff[31] != dms_ff[15];
               job[0].num = W'(dist_abs) * W'(1000);
               job[0].den = W'({dms_abs, 8'd0});
               job[1].start = 1'b1; job[1].neg = head_ff[31] != dms_ff[15];
               job[1].num = W'(head_abs) * W'(1000);
               job[1].den = W'({dms_abs, 8'd0});
            end else if (busy == '0) st_in = ddwo_pkg::StOut;
         end
         // hold the finished transaction until the output register is free
         ddwo_pkg::StOut: if (!out_v_ff || rsp_ch.ready) st_in = ddwo_pkg::StIdle;
         default: st_in = ddwo_pkg::StIdle;
      endcase
   end

   assign req_ch.ready = (st_ff == ddwo_pkg::StIdle);
   assign rsp_ch.valid = out_v_ff;
   assign rsp_ch.data = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ddwo_pkg::StIdle; out_v_ff <= 1'b0; wait_ff <= 1'b0;
         tick_ff <= 32'd13493069; radius_ff <= 16'd4129; base_ff <= 20'd22020;
         prev_l_ff <= '0; prev_r_ff <= '0; prev_st_ff <= '0; dms_ff <= '0;
         primed_ff <= 1'b0; ltot_ff <= '0; rtot_ff <= '0;
         lspd_ff <= '0; rspd_ff <= '0;
      end else begin
         st_ff <= st_in;
         if (st_ff == ddwo_pkg::StOut && st_in == ddwo_pkg::StIdle) out_v_ff <= 1'b1;
         else if (rsp_ch.valid && rsp_ch.ready) out_v_ff <= 1'b0;
         if (csr_write) begin
            unique case (csr_index)
               ddwo_pkg::RegTickAngle: tick_ff <= csr_data;
               ddwo_pkg::RegWheelRadius: radius_ff <= csr_data[15:0];
               ddwo_pkg::RegWheelBase: base_ff <= csr_data[19:0];
               default: ;
            endcase
         end
         // launch flag: set in the cycle after a lane start, then watch busy
         wait_ff <= (st_in == st_ff) && (job[0].start || wait_ff);
         unique case (st_ff)
            ddwo_pkg::StIdle: if (req_ch.valid && req_ch.ready) cur_ff <= req_ch.data;
            ddwo_pkg::StMul: begin
               sl_ff <= 48'($signed(dl)) * $signed({1'b0, tick_ff});
               sr_ff <= 48'($signed(dr)) * $signed({1'b0, tick_ff});
               prev_l_ff <= cur_ff.left_count; prev_r_ff <= cur_ff.right_count;
               primed_ff <= 1'b1;
            end
            ddwo_pkg::StHead: if (wait_ff && !busy[0]) begin
               head_ff <= res[0];
               dist_ff <= ddwo_pkg::sat32(sum[48], W'(dist_prod >> 25));
               ltot_ff <= ltot_ff + sl_ff; rtot_ff <= rtot_ff + sr_ff;
            end
            ddwo_pkg::StWheel: if (st_in == ddwo_pkg::StBody) begin
               if (stamp_new) begin
                  dms_ff <= dt_raw; prev_st_ff <= cur_ff.stamp_ms;
                  lspd_ff <= (dt_raw == 16'd0) ? 32'd0 : res[0];
                  rspd_ff <= (dt_raw == 16'd0) ? 32'd0 : res[1];
               end
            end
            ddwo_pkg::StBody: begin
               fwd_ff <= (dms_ff == 16'd0) ? 32'd0 : res[0];
               turn_ff <= (dms_ff == 16'd0) ? 32'd0 : res[1];
            end
            ddwo_pkg::StOut: if (st_in == ddwo_pkg::StIdle) begin
               if (cur_ff.operation == ddwo_pkg::OpClear) begin
                  ltot_ff <= '0; rtot_ff <= '0; lspd_ff <= '0; rspd_ff <= '0;
                  out_ff <= '0;
               end else begin
                  out_ff.distance_step <= dist_ff; out_ff.heading_step <= head_ff;
                  out_ff.forward_rate <= fwd_ff; out_ff.turn_rate <= turn_ff;
                  out_ff.left_angle <= ltot_ff; out_ff.right_angle <= rtot_ff;
                  out_ff.left_rate <= lspd_ff; out_ff.right_rate <= rspd_ff;
               end
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire
